@@ hw/rtl/bsa_pkg.sv @@
package bsa_pkg;

  localparam int ADDR_W      = 32;
  localparam int MAP_ENTRIES = 64;
  localparam int SLOT_W      = $clog2(MAP_ENTRIES);
  localparam int COUNT_W     = $clog2(MAP_ENTRIES + 1);
  localparam int BATCH_W     = 4;

  localparam int DEF_SLOTS_PER_BATCH = 8;
  localparam int DEF_SLOT_BYTES      = 8;
  localparam int DEF_MAX_BATCHES     = 8;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_OOM       = 3'd1,
    ST_DOUBLE    = 3'd2,
    ST_UNALIGNED = 3'd3,
    ST_UNMANAGED = 3'd4
  } status_t;

  typedef struct packed {
    logic [ADDR_W-1:0] slot_address;
    status_t           status;
    logic              batch_opened;
  } bsa_result_t;

  // Low n bits set, n from 0 to MAP_ENTRIES.
  function automatic logic [MAP_ENTRIES-1:0] low_mask(input logic [COUNT_W-1:0] n);
    logic [MAP_ENTRIES-1:0] m;
    for (int i = 0; i < MAP_ENTRIES; i++) begin
      m[i] = (COUNT_W'(i) < n);
    end
    return m;
  endfunction

  // Index of the set bit of a one-hot (or zero) vector.
  function automatic logic [SLOT_W-1:0] onehot_index(input logic [MAP_ENTRIES-1:0] v);
    logic [SLOT_W-1:0] idx;
    idx = '0;
    for (int i = 0; i < MAP_ENTRIES; i++) begin
      if (v[i]) begin
        idx = idx | SLOT_W'(i);
      end
    end
    return idx;
  endfunction

endpackage

@@ hw/rtl/bsa_engine.sv @@
module bsa_engine
  import bsa_pkg::*;
#(
  parameter int SLOTS_PER_BATCH = DEF_SLOTS_PER_BATCH,
  parameter int SLOT_BYTES      = DEF_SLOT_BYTES,
  parameter int MAX_BATCHES     = DEF_MAX_BATCHES
) (
  input  logic              clk,
  input  logic              rst,
  input  logic [ADDR_W-1:0] pool_base,
  input  logic              fire,
  input  logic              opcode,
  input  logic [ADDR_W-1:0] address,
  output bsa_result_t       result
);

  localparam int PROD_W = BATCH_W + COUNT_W;
  localparam int AREA_W = $clog2(MAP_ENTRIES * SLOT_BYTES + 1);

  logic [MAP_ENTRIES-1:0] free_map, free_map_next;
  logic [BATCH_W-1:0]     active_batches, active_batches_next;

  logic [PROD_W-1:0]      active_raw, next_raw;
  logic [COUNT_W-1:0]     active_slots;
  logic                   can_open;
  logic [MAP_ENTRIES-1:0] active_mask, avail, lowest, open_bits;
  logic                   have;
  logic [SLOT_W-1:0]      alloc_slot;

  logic [ADDR_W-1:0]      offset;
  logic [AREA_W-1:0]      area;
  logic                   in_range;
  logic [MAP_ENTRIES-1:0] match;
  logic [SLOT_W-1:0]      free_slot;

  always_comb begin
    active_raw   = PROD_W'(active_batches) * PROD_W'(SLOTS_PER_BATCH);
    next_raw     = active_raw + PROD_W'(SLOTS_PER_BATCH);
    active_slots = (active_raw > PROD_W'(MAP_ENTRIES)) ? COUNT_W'(MAP_ENTRIES)
                                                       : active_raw[COUNT_W-1:0];
    can_open     = (active_batches < BATCH_W'(MAX_BATCHES)) &&
                   (next_raw <= PROD_W'(MAP_ENTRIES));
    active_mask  = low_mask(active_slots);
    avail        = free_map & active_mask;
    have         = |avail;
    lowest       = avail & (~avail + MAP_ENTRIES'(1));
    // the opened batch starts right where the active area ends
    alloc_slot   = have ? onehot_index(lowest) : active_slots[SLOT_W-1:0];
    open_bits    = low_mask(next_raw[COUNT_W-1:0]) & ~active_mask;

    offset   = address - pool_base;
    area     = AREA_W'(active_slots) * AREA_W'(SLOT_BYTES);
    in_range = offset < ADDR_W'(area);
    for (int s = 0; s < MAP_ENTRIES; s++) begin
      match[s] = (offset == ADDR_W'(s * SLOT_BYTES));
    end
    free_slot = onehot_index(match);
  end

  always_comb begin
    free_map_next       = free_map;
    active_batches_next = active_batches;
    result.slot_address = '0;
    result.status       = ST_OK;
    result.batch_opened = 1'b0;
    if (opcode == OP_ALLOC) begin
      if (have || can_open) begin
        if (!have) begin
          free_map_next       = free_map | open_bits;
          active_batches_next = active_batches + BATCH_W'(1);
          result.batch_opened = 1'b1;
        end
        free_map_next[alloc_slot] = 1'b0;
        result.slot_address = pool_base + ADDR_W'(alloc_slot) * ADDR_W'(SLOT_BYTES);
      end else begin
        result.status = ST_OOM;
      end
    end else begin
      if (!in_range) begin
        result.status = ST_UNMANAGED;
      end else if (!(|match)) begin
        result.status = ST_UNALIGNED;
      end else if (free_map[free_slot]) begin
        result.status = ST_DOUBLE;
      end else begin
        free_map_next[free_slot] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      free_map       <= '1;
      active_batches <= BATCH_W'(1);
    end else if (fire) begin
      free_map       <= free_map_next;
      active_batches <= active_batches_next;
    end
  end

endmodule

@@ hw/rtl/bitmap_slot_allocator.sv @@
// Fixed-size slot allocator over a pool of batches in a 64-slot free map.
// Request channel: in_valid/in_ready with opcode (0 allocate, 1 free) and
// address (byte address to free). Result channel: out_valid/out_ready with
// slot_address, status (0 ok, 1 out of memory, 2 double free, 3 unaligned,
// 4 not managed) and batch_opened. Every request gives exactly one result.
// cfg_we/cfg_wdata write pool_base; write it only while no request is in
// flight.
// An accepted word waits in the request register; its result moves on to the result register.
// Throughput: one request per cycle while the receiver keeps out_ready high; the free map
// and batch count are read and updated between the request register and the
// result register, so back-to-back requests see each other's effects.
// When the receiver stalls, the result register holds and the request
// register fills, after which in_ready drops; nothing is lost.
// Reset clears both stages, sets pool_base to zero, marks every slot free
// and leaves one batch active.
module bitmap_slot_allocator
  import bsa_pkg::*;
#(
  parameter int SLOTS_PER_BATCH = DEF_SLOTS_PER_BATCH,
  parameter int SLOT_BYTES      = DEF_SLOT_BYTES,
  parameter int MAX_BATCHES     = DEF_MAX_BATCHES
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [ADDR_W-1:0] cfg_wdata,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              opcode,
  input  logic [ADDR_W-1:0] address,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [ADDR_W-1:0] slot_address,
  output logic [2:0]        status,
  output logic              batch_opened
);

  logic [ADDR_W-1:0] pool_base;
  logic              req_valid;
  logic              req_opcode;
  logic [ADDR_W-1:0] req_address;
  logic              advance;
  bsa_result_t       result;
  bsa_result_t       out_word;

  assign advance  = req_valid && (!out_valid || out_ready);
  assign in_ready = !req_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      pool_base <= '0;
    end else if (cfg_we) begin
      pool_base <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      req_valid <= 1'b1;
    end else if (advance) begin
      req_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      req_opcode  <= opcode;
      req_address <= address;
    end
  end

  bsa_engine #(
    .SLOTS_PER_BATCH(SLOTS_PER_BATCH),
    .SLOT_BYTES     (SLOT_BYTES),
    .MAX_BATCHES    (MAX_BATCHES)
  ) u_engine (
    .clk      (clk),
    .rst      (rst),
    .pool_base(pool_base),
    .fire     (advance),
    .opcode   (req_opcode),
    .address  (req_address),
    .result   (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_word <= result;
    end
  end

  assign slot_address = out_word.slot_address;
  assign status       = out_word.status;
  assign batch_opened = out_word.batch_opened;

  a_advance_lands: assert property (@(posedge clk) disable iff (rst)
    advance |=> out_valid)
    else $error("request advanced but no result word followed");

  a_stalled_req_kept: assert property (@(posedge clk) disable iff (rst)
    req_valid && !advance |=> req_valid)
    else $error("stalled request dropped");

  a_open_is_ok: assert property (@(posedge clk) disable iff (rst)
    out_valid && batch_opened |-> status == ST_OK && slot_address == pool_base +
      ADDR_W'(slot_address - pool_base))
    else $error("batch opened on a failed allocation");

  a_fail_zero_addr: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != ST_OK |-> slot_address == '0 && !batch_opened)
    else $error("failed request carries an address or batch flag");

endmodule

@@ bench/testbench.sv @@
`timescale 1ns / 100ps

module testbench;
  import bsa_pkg::*;

  localparam int SPB         = DEF_SLOTS_PER_BATCH;
  localparam int SB          = DEF_SLOT_BYTES;
  localparam int MAXB        = DEF_MAX_BATCHES;
  localparam int CYCLE_LIMIT = 500000;
  localparam int PHASES      = 10;
  localparam int PHASE_WORDS = 175;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              cfg_we = 1'b0;
  logic [ADDR_W-1:0] cfg_wdata = '0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic              opcode = OP_ALLOC;
  logic [ADDR_W-1:0] address = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [ADDR_W-1:0] slot_address;
  logic [2:0]        status;
  logic              batch_opened;

  bitmap_slot_allocator dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .opcode       (opcode),
    .address      (address),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .slot_address (slot_address),
    .status       (status),
    .batch_opened (batch_opened)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // shadow of the allocator state
  logic [MAP_ENTRIES-1:0] free_map = '1;
  logic [BATCH_W-1:0]     shadow_batches = 1;
  logic [ADDR_W-1:0]      base_addr = '0;

  bsa_result_t pending_results[$];
  int          mismatches = 0;
  int          results_seen = 0;
  int          burst_left = 0;
  int unsigned cycle_count = 0;

  typedef struct {
    logic              op;
    logic [ADDR_W-1:0] a;
    logic              typed;
    logic [ADDR_W-1:0] want_addr;
    status_t           want_status;
    logic              want_opened;
  } directed_row_t;

  // pool_base is zero here; one batch of 64 bytes is active at the start
  directed_row_t directed_rows [0:21] = '{
    '{OP_FREE,  32'h0000_0000, 1'b1, 32'd0,  ST_DOUBLE,    1'b0},
    '{OP_ALLOC, 32'hFFFF_FFFF, 1'b1, 32'd0,  ST_OK,        1'b0},
    '{OP_FREE,  32'h0000_0004, 1'b1, 32'd0,  ST_UNALIGNED, 1'b0},
    '{OP_FREE,  32'h0000_0040, 1'b1, 32'd0,  ST_UNMANAGED, 1'b0},
    '{OP_FREE,  32'hFFFF_FFFF, 1'b1, 32'd0,  ST_UNMANAGED, 1'b0},
    '{OP_FREE,  32'h0000_0000, 1'b1, 32'd0,  ST_OK,        1'b0},
    '{OP_ALLOC, 32'h0000_0000, 1'b1, 32'd0,  ST_OK,        1'b0},
    '{OP_ALLOC, 32'h0000_0000, 1'b0, 32'd0,  ST_OK,        1'b0},
    '{OP_ALLOC, 32'h0000_0000, 1'b0, 32'd0,  ST_OK,        1'b0},
    '{OP_ALLOC, 32'h0000_0000, 1'b0, 32'd0,  ST_OK,        1'b0},
    '{OP_ALLOC, 32'h0000_0000, 1'b0, 32'd0,  ST_OK,        1'b0},
    '{OP_ALLOC, 32'h0000_0000, 1'b0, 32'd0,  ST_OK,        1'b0},
    '{OP_ALLOC, 32'h0000_0000, 1'b0, 32'd0,  ST_OK,        1'b0},
    '{OP_ALLOC, 32'h0000_0000, 1'b1, 32'd56, ST_OK,        1'b0},
    // first batch full: this one opens batch 1
    '{OP_ALLOC, 32'h0000_0000, 1'b1, 32'd64, ST_OK,        1'b1},
    '{OP_FREE,  32'h0000_0040, 1'b1, 32'd0,  ST_OK,        1'b0},
    '{OP_FREE,  32'h0000_0040, 1'b1, 32'd0,  ST_DOUBLE,    1'b0},
    '{OP_FREE,  32'h0000_0080, 1'b1, 32'd0,  ST_UNMANAGED, 1'b0},
    '{OP_FREE,  32'h0000_007F, 1'b1, 32'd0,  ST_UNALIGNED, 1'b0},
    '{OP_FREE,  32'h0000_0078, 1'b1, 32'd0,  ST_DOUBLE,    1'b0},
    '{OP_ALLOC, 32'h0000_0000, 1'b1, 32'd64, ST_OK,        1'b0},
    '{OP_FREE,  32'h8000_0000, 1'b1, 32'd0,  ST_UNMANAGED, 1'b0}
  };

  function automatic int slots_within(input int batches);
    int n;
    n = batches * SPB;
    return (n > MAP_ENTRIES) ? MAP_ENTRIES : n;
  endfunction

  function automatic logic [MAP_ENTRIES-1:0] ones_below(input int n);
    if (n >= MAP_ENTRIES) return '1;
    return (64'd1 << n) - 64'd1;
  endfunction

  // Applies one request to the shadow state and returns the word it yields.
  function automatic bsa_result_t allocator_step(input logic op,
                                                 input logic [ADDR_W-1:0] a);
    bsa_result_t            r;
    int                     active_slots;
    int                     next_end;
    int                     slot;
    logic [MAP_ENTRIES-1:0] avail;
    logic [ADDR_W-1:0]      offset;
    logic [63:0]            area;
    r.slot_address = '0;
    r.status = ST_OK;
    r.batch_opened = 1'b0;
    active_slots = slots_within(int'(shadow_batches));
    slot = -1;
    if (op == OP_ALLOC) begin
      avail = free_map & ones_below(active_slots);
      for (int i = MAP_ENTRIES - 1; i >= 0; i--) begin
        if (avail[i]) slot = i;
      end
      if (slot < 0) begin
        next_end = (int'(shadow_batches) + 1) * SPB;
        if (int'(shadow_batches) < MAXB && next_end <= MAP_ENTRIES) begin
          free_map = free_map | (ones_below(next_end) & ~ones_below(active_slots));
          shadow_batches = shadow_batches + 1'b1;
          slot = active_slots;
          r.batch_opened = 1'b1;
        end
      end
      if (slot >= 0) begin
        free_map[slot] = 1'b0;
        r.slot_address = base_addr + ADDR_W'(slot * SB);
      end else begin
        r.status = ST_OOM;
      end
    end else begin
      offset = a - base_addr;  // wraps back exactly
      area = 64'(active_slots) * 64'(SB);
      if (64'(offset) >= area) begin
        r.status = ST_UNMANAGED;
      end else if (offset % SB != 0) begin
        r.status = ST_UNALIGNED;
      end else begin
        slot = int'(offset / SB);
        if (free_map[slot]) r.status = ST_DOUBLE;
        else free_map[slot] = 1'b1;
      end
    end
    return r;
  endfunction

  // Half aim to free a slot in use; the rest free a random slot, misaligned and stray addresses.
  function automatic logic [ADDR_W-1:0] free_target();
    int   n;
    int   k;
    int   start;
    int   pick;
    logic found;
    n = slots_within(int'(shadow_batches));
    pick = $urandom_range(0, 99);
    start = $urandom_range(0, n - 1);
    k = start;
    found = 1'b0;
    if (pick < 50) begin
      for (int j = 0; j < n; j++) begin
        if (!found && !free_map[(start + j) % n]) begin
          k = (start + j) % n;
          found = 1'b1;
        end
      end
      return base_addr + ADDR_W'(k * SB);
    end else if (pick < 65) begin
      return base_addr + ADDR_W'(k * SB);
    end else if (pick < 80) begin
      return base_addr + ADDR_W'(k * SB + $urandom_range(1, SB - 1));
    end else if (pick < 85) begin
      return base_addr + ADDR_W'(n * SB + $urandom_range(0, 255));
    end else if (pick < 90) begin
      return base_addr - ADDR_W'($urandom_range(1, 64));
    end
    return $urandom();
  endfunction

  task automatic report_mismatch(input string what);
    $display("tb: mismatch at cycle %0d: %s", cycle_count, what);
    mismatches++;
  endtask

  task automatic send_word(input logic op, input logic [ADDR_W-1:0] a,
                           input bsa_result_t want);
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                               : $urandom_range(1, 16);
    end
    burst_left--;
    opcode   <= op;
    address  <= a;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    pending_results.push_back(want);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    burst_left = 0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic set_pool_base(input logic [ADDR_W-1:0] v);
    drain_results();
    cfg_wdata <= v;
    cfg_we    <= 1'b1;
    @(posedge clk);
    cfg_we    <= 1'b0;
    base_addr = v;
  endtask

  initial begin : stimulus
    bsa_result_t       want;
    logic              op;
    logic [ADDR_W-1:0] a;
    logic [ADDR_W-1:0] next_base;
    int                alloc_pct;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_rows[r]) begin
      want = allocator_step(directed_rows[r].op, directed_rows[r].a);
      if (directed_rows[r].typed) begin
        want.slot_address = directed_rows[r].want_addr;
        want.status       = directed_rows[r].want_status;
        want.batch_opened = directed_rows[r].want_opened;
      end
      send_word(directed_rows[r].op, directed_rows[r].a, want);
    end

    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: next_base = 32'hFFFF_FFF0;  // pool wraps past zero
        1: next_base = 32'hFFFF_FFFF;
        2: next_base = 32'h0000_0000;
        default: begin
          next_base = $urandom();
          if ($urandom_range(0, 1) == 1) next_base[2:0] = 3'b000;
        end
      endcase
      set_pool_base(next_base);
      // cycle through filling, mixed and emptying phases
      alloc_pct = (p % 3 == 0) ? 80 : (p % 3 == 1) ? 50 : 20;
      for (int i = 0; i < PHASE_WORDS; i++) begin
        if (p == 4 && i == 90) drain_results();
        op = ($urandom_range(0, 99) < alloc_pct) ? OP_ALLOC : OP_FREE;
        a = (op == OP_FREE) ? free_target() : $urandom();
        want = allocator_step(op, a);
        send_word(op, a, want);
      end
    end

    drain_results();
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // receiver: random ready patterns, plus a long hold after 400 words and every 500 after that
  initial begin : result_sink
    int pattern;
    int run_left;
    int hold_at;
    pattern = 0;
    run_left = 0;
    hold_at = 400;
    wait (rst == 1'b0);
    forever begin
      @(posedge clk);
      if (results_seen >= hold_at) begin
        hold_at += 500;
        out_ready <= 1'b0;
        repeat (60) @(posedge clk);
      end
      if (run_left == 0) begin
        pattern  = $urandom_range(0, 2);
        run_left = $urandom_range(10, 80);
      end
      run_left--;
      case (pattern)
        0: out_ready <= 1'b1;
        1: out_ready <= ($urandom_range(0, 1) == 1);
        default: out_ready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  always @(posedge clk) begin : result_check
    bsa_result_t want;
    if (!rst && out_valid && out_ready) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        report_mismatch("result word with none pending");
      end else begin
        want = pending_results.pop_front();
        if (slot_address !== want.slot_address)
          report_mismatch($sformatf("slot_address %h, want %h", slot_address,
                                    want.slot_address));
        if (status !== want.status)
          report_mismatch($sformatf("status %0d, want %0d", status, want.status));
        if (batch_opened !== want.batch_opened)
          report_mismatch($sformatf("batch_opened %b, want %b", batch_opened,
                                    want.batch_opened));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

endmodule
